// ===== rtl/glt_pkg.sv =====
// Shared package of the generation-tagged lease table.
// Holds field widths, default sizes, op codes, sequencer states and the entry layout.
// No dependencies.
package glt_pkg;

	// Default table size
	localparam int KINDS_DEF     = 4;
	localparam int INSTANCES_DEF = 8;

	// Field widths fixed by the interface
	localparam int OP_W    = 2;
	localparam int KIND_W  = 3;
	localparam int IDX_W   = 4;
	localparam int OWNER_W = 4;
	localparam int GEN_W   = 32;
	localparam int GIDX_W  = 3;

	typedef enum logic [OP_W-1:0] {
		OP_ACQ     = 2'd0,
		OP_ACQ_ANY = 2'd1,
		OP_CHECK   = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_RESP
	} state_t;

	// One table entry as stored in the RAM
	typedef struct packed {
		logic [OWNER_W-1:0] owner;
		logic [GEN_W-1:0]   gen;
	} entry_t;

endpackage

// ===== rtl/glt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Parameters set word width and depth; no package dependency.
module glt_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 32,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/generation_tagged_lease_table_unit.sv =====
// Top level of the generation-tagged lease table: sequencer, tag counter, entry valid bits.
// Depends on glt_pkg and glt_ram.
//
//  channel   signals                                              flow
//  -------   ---------------------------------------------------  ---------------------------
//  command   start, busy, op, kind, index, count, owner,          transfer when start && !busy
//            lease_generation, lease_held
//  result    done, ok, granted_index, granted_generation          one-cycle strobe on done
//
// An op rejected at decode shows its result in the cycle after the transfer; a named acquire,
// check or release reads and evaluates one entry in the read and evaluate states, then shows it.
// A first-free scan passes through the read and evaluate states for each column examined,
// one read on the table RAM read port per column, up to count columns (at most INSTANCES).
// busy stays high through the result strobe; the next command can transfer the cycle after done.
// Reset clears the entry valid bits at once (unwritten entries read as free, tag 0) and
// sets the tag counter to 1; no clearing pass. The receiver cannot stall results.
module generation_tagged_lease_table_unit
	import glt_pkg::*;
#(
	parameter int KINDS     = KINDS_DEF,
	parameter int INSTANCES = INSTANCES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [OP_W-1:0]    op,
	input  logic [KIND_W-1:0]  kind,
	input  logic [IDX_W-1:0]   index,
	input  logic [IDX_W-1:0]   count,
	input  logic [OWNER_W-1:0] owner,
	input  logic [GEN_W-1:0]   lease_generation,
	input  logic               lease_held,
	output logic               done,
	output logic               ok,
	output logic [GIDX_W-1:0]  granted_index,
	output logic [GEN_W-1:0]   granted_generation
);

	localparam int SLOTS  = KINDS * INSTANCES;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int COL_W  = (INSTANCES > 1) ? $clog2(INSTANCES) : 1;
	localparam logic [KIND_W:0] KINDS_L    = (KIND_W + 1)'(KINDS);
	localparam logic [IDX_W:0]  INSTANCES_L = (IDX_W + 1)'(INSTANCES);
	localparam logic [SLOT_W-1:0] ROW_STEP = SLOT_W'(INSTANCES);

	state_t             state_q, state_d;
	op_t                op_q;
	logic [KIND_W-1:0]  kind_q;
	logic [COL_W-1:0]   col_q, last_col_q;
	logic [OWNER_W-1:0] owner_q;
	logic [GEN_W-1:0]   lgen_q;
	logic [GEN_W-1:0]   next_gen_q;
	logic [SLOTS-1:0]   valid_q;
	logic               rd_valid_q;
	logic               ok_q;
	logic [GIDX_W-1:0]  gidx_q;
	logic [GEN_W-1:0]   ggen_q;

	logic               accept;
	logic               cmd_ok;
	logic               kind_ok, idx_ok;
	logic [IDX_W:0]     lim, lim_m1;
	logic [SLOT_W-1:0]  slot;
	logic               ram_we;
	entry_t             ram_wdata;
	logic [$bits(entry_t)-1:0] ram_rdata;
	entry_t             entry;
	logic               is_free, is_match, more_cols;
	logic [GEN_W-1:0]   tag;
	logic               res_load, res_ok, gen_bump, col_step;
	logic [GIDX_W-1:0]  res_gidx;
	logic [GEN_W-1:0]   res_ggen;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign done   = (state_q == ST_RESP);

	// command decode: range checks and scan limit
	assign kind_ok = {1'b0, kind} < KINDS_L;
	assign idx_ok  = {1'b0, index} < INSTANCES_L;
	assign lim     = ({1'b0, count} > INSTANCES_L) ? INSTANCES_L : {1'b0, count};
	assign lim_m1  = lim - 1'b1;

	always_comb begin
		unique case (op_t'(op))
			OP_ACQ:     cmd_ok = kind_ok && idx_ok && (owner != '0);
			OP_ACQ_ANY: cmd_ok = kind_ok && (owner != '0) && (count != '0);
			OP_CHECK,
			OP_RELEASE: cmd_ok = lease_held && kind_ok && idx_ok;
			default:    cmd_ok = 1'b0;
		endcase
	end

	// table address of the entry under work
	assign slot = SLOT_W'(kind_q) * ROW_STEP + SLOT_W'(col_q);

	glt_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot),
		.wdata(ram_wdata),
		.raddr(slot),
		.rdata(ram_rdata)
	);

	// shared compare unit and tag incrementer
	assign entry     = rd_valid_q ? entry_t'(ram_rdata) : '0;
	assign is_free   = (entry.owner == '0);
	assign is_match  = (entry.owner == owner_q) && (entry.gen == lgen_q);
	assign more_cols = (col_q != last_col_q);
	assign tag       = (next_gen_q == '0) ? GEN_W'(1) : next_gen_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = cmd_ok ? ST_READ : ST_RESP;
				end
			end
			ST_READ: state_d = ST_EVAL;
			ST_EVAL: begin
				if ((op_q == OP_ACQ_ANY) && !is_free && more_cols) begin
					state_d = ST_READ;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = '0;
		res_load  = 1'b0;
		res_ok    = 1'b0;
		res_gidx  = '0;
		res_ggen  = '0;
		gen_bump  = 1'b0;
		col_step  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				res_load = accept && !cmd_ok;
			end
			ST_EVAL: begin
				unique case (op_q)
					OP_ACQ, OP_ACQ_ANY: begin
						if (is_free) begin
							ram_we          = 1'b1;
							ram_wdata.owner = owner_q;
							ram_wdata.gen   = tag;
							gen_bump        = 1'b1;
							res_load        = 1'b1;
							res_ok          = 1'b1;
							res_gidx        = GIDX_W'(col_q);
							res_ggen        = tag;
						end else if ((op_q == OP_ACQ_ANY) && more_cols) begin
							col_step = 1'b1;
						end else begin
							res_load = 1'b1;
						end
					end
					OP_CHECK: begin
						res_load = 1'b1;
						res_ok   = is_match;
					end
					OP_RELEASE: begin
						// free the entry, keep its tag
						res_load        = 1'b1;
						res_ok          = is_match;
						ram_we          = is_match;
						ram_wdata.owner = '0;
						ram_wdata.gen   = entry.gen;
					end
					default: res_load = 1'b1;
				endcase
			end
			ST_READ, ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			next_gen_q <= GEN_W'(1);
			valid_q    <= '0;
		end else begin
			state_q <= state_d;
			if (gen_bump) begin
				next_gen_q <= tag + 1'b1;
			end
			if (ram_we) begin
				valid_q[slot] <= 1'b1;
			end
		end
	end

	// command capture, scan column, read valid and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_t'(op);
			kind_q  <= kind;
			owner_q <= owner;
			lgen_q  <= lease_generation;
			if (op_t'(op) == OP_ACQ_ANY) begin
				col_q      <= '0;
				last_col_q <= lim_m1[COL_W-1:0];
			end else begin
				col_q      <= index[COL_W-1:0];
				last_col_q <= index[COL_W-1:0];
			end
		end else if (col_step) begin
			col_q <= col_q + 1'b1;
		end
		if (state_q == ST_READ) begin
			rd_valid_q <= valid_q[slot];
		end
		if (res_load) begin
			ok_q   <= res_ok;
			gidx_q <= res_gidx;
			ggen_q <= res_ggen;
		end
	end

	assign ok                 = ok_q;
	assign granted_index      = gidx_q;
	assign granted_generation = ggen_q;

endmodule

// ===== rtl/glt_checker.sv =====
// Port-level checker for the generation-tagged lease table, bound to the top level.
// Depends on glt_pkg widths and generation_tagged_lease_table_unit ports.
module glt_checker
	import glt_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic              ok,
	input logic [GIDX_W-1:0] granted_index,
	input logic [GEN_W-1:0]  granted_generation
);

	// a command transfer puts the block to work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after command transfer");

	// the result ends the operation
	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy still high after result");

	// a failed op grants nothing
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> ((granted_index == '0) && (granted_generation == '0)))
		else $error("granted fields not zero on failure");

	// one strobe per result
	a_strobe_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

endmodule

bind generation_tagged_lease_table_unit glt_checker u_glt_checker (.*);

// ===== test/tb_generation_tagged_lease_table_unit.sv =====
// Testbench for generation_tagged_lease_table_unit: directed and random lease traffic,
// with every result checked against a lease table predictor kept in the testbench.
// Depends on glt_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_generation_tagged_lease_table_unit;
	import glt_pkg::*;

	localparam int KINDS     = KINDS_DEF;
	localparam int INSTANCES = INSTANCES_DEF;
	localparam int SLOTS     = KINDS * INSTANCES;
	localparam int MAX_PRINT = 100;

	typedef struct packed {
		logic              ok;
		logic [GIDX_W-1:0] gidx;
		logic [GEN_W-1:0]  ggen;
	} lease_result_t;

	// A lease as software would hold it
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [IDX_W-1:0]   idx;
		logic [OWNER_W-1:0] owner;
		logic [GEN_W-1:0]   gen;
		logic               held;
	} lease_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	op_t                op;
	logic [KIND_W-1:0]  kind;
	logic [IDX_W-1:0]   index;
	logic [IDX_W-1:0]   count;
	logic [OWNER_W-1:0] owner;
	logic [GEN_W-1:0]   lease_generation;
	logic               lease_held;
	logic               done;
	logic               ok;
	logic [GIDX_W-1:0]  granted_index;
	logic [GEN_W-1:0]   granted_generation;

	// Predictor state: table entries and the tag counter
	logic [OWNER_W-1:0] slot_owner [SLOTS];
	logic [GEN_W-1:0]   slot_tag   [SLOTS];
	logic [GEN_W-1:0]   next_tag;

	lease_result_t pending_results[$];
	lease_t        held_leases[$];
	int            mismatches;
	int            sender_idle_pct;

	generation_tagged_lease_table_unit #(
		.KINDS(KINDS),
		.INSTANCES(INSTANCES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.kind(kind),
		.index(index),
		.count(count),
		.owner(owner),
		.lease_generation(lease_generation),
		.lease_held(lease_held),
		.done(done),
		.ok(ok),
		.granted_index(granted_index),
		.granted_generation(granted_generation)
	);

	// 10 ns clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	// Claim one entry; tag 0 is never handed out
	function automatic bit try_grant(input logic [KIND_W-1:0] k, input int col,
		input logic [OWNER_W-1:0] ow, output logic [GEN_W-1:0] tag);
		int slot;
		tag = '0;
		if (int'(k) >= KINDS || col >= INSTANCES || ow == '0)
			return 1'b0;
		slot = int'(k) * INSTANCES + col;
		if (slot_owner[slot] != '0)
			return 1'b0;
		tag = next_tag;
		next_tag = next_tag + 1;
		if (tag == '0) begin
			tag = next_tag;
			next_tag = next_tag + 1;
		end
		slot_owner[slot] = ow;
		slot_tag[slot]   = tag;
		return 1'b1;
	endfunction

	// Lease still valid: held, in range, owner and tag both match the entry
	function automatic bit lease_valid(input logic [KIND_W-1:0] k, input logic [IDX_W-1:0] i,
		input logic [OWNER_W-1:0] ow, input logic [GEN_W-1:0] lg, input logic lh,
		output int slot);
		slot = 0;
		if (!lh || int'(k) >= KINDS || int'(i) >= INSTANCES)
			return 1'b0;
		slot = int'(k) * INSTANCES + int'(i);
		return slot_owner[slot] == ow && slot_tag[slot] == lg;
	endfunction

	function automatic lease_result_t apply_lease_op(input op_t o, input logic [KIND_W-1:0] k,
		input logic [IDX_W-1:0] i, input logic [IDX_W-1:0] c, input logic [OWNER_W-1:0] ow,
		input logic [GEN_W-1:0] lg, input logic lh);
		lease_result_t r;
		logic [GEN_W-1:0] tag;
		int lim;
		int col;
		int slot;
		r = '0;
		case (o)
			OP_ACQ: begin
				if (try_grant(k, int'(i), ow, tag)) begin
					r.ok   = 1'b1;
					r.gidx = i[GIDX_W-1:0];
					r.ggen = tag;
				end
			end
			OP_ACQ_ANY: begin
				lim = (int'(c) > INSTANCES) ? INSTANCES : int'(c);
				for (col = 0; col < lim && !r.ok; col++) begin
					if (try_grant(k, col, ow, tag)) begin
						r.ok   = 1'b1;
						r.gidx = col[GIDX_W-1:0];
						r.ggen = tag;
					end
				end
			end
			OP_CHECK: begin
				r.ok = lease_valid(k, i, ow, lg, lh, slot);
			end
			default: begin
				// release keeps the tag, frees the owner
				if (lease_valid(k, i, ow, lg, lh, slot)) begin
					slot_owner[slot] = '0;
					r.ok = 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------- result checker

	always @(posedge clk) begin : result_check
		lease_result_t exp_r;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches < MAX_PRINT)
					$display("%0t: result with no pending transfer, ok %0d idx %0d gen %0h",
						$time, ok, granted_index, granted_generation);
			end else begin
				exp_r = pending_results.pop_front();
				if (ok !== exp_r.ok) begin
					mismatches++;
					if (mismatches < MAX_PRINT)
						$display("%0t: ok mismatch, expected %0d actual %0d",
							$time, exp_r.ok, ok);
				end
				if (granted_index !== exp_r.gidx) begin
					mismatches++;
					if (mismatches < MAX_PRINT)
						$display("%0t: granted_index mismatch, expected %0d actual %0d",
							$time, exp_r.gidx, granted_index);
				end
				if (granted_generation !== exp_r.ggen) begin
					mismatches++;
					if (mismatches < MAX_PRINT)
						$display("%0t: granted_generation mismatch, expected %0h actual %0h",
							$time, exp_r.ggen, granted_generation);
				end
			end
		end
	end

	// ---------------------------------------------------------------- driver

	// Send one command; start stays high after the transfer so back-to-back
	// commands never lower and raise it in one step
	task automatic send_cmd(input op_t o, input logic [KIND_W-1:0] k,
		input logic [IDX_W-1:0] i, input logic [IDX_W-1:0] c, input logic [OWNER_W-1:0] ow,
		input logic [GEN_W-1:0] lg, input logic lh, output lease_result_t r);
		while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start            <= 1'b1;
		op               <= o;
		kind             <= k;
		index            <= i;
		count            <= c;
		owner            <= ow;
		lease_generation <= lg;
		lease_held       <= lh;
		do @(posedge clk); while (busy);
		r = apply_lease_op(o, k, i, c, ow, lg, lh);
		pending_results.push_back(r);
	endtask

	// Hold off until every pending result has come back
	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Corrupt one field of a lease so that it no longer matches
	function automatic lease_t spoil_lease(input lease_t l);
		lease_t s;
		s = l;
		case ($urandom_range(3))
			0: s.held  = 1'b0;
			1: s.owner = l.owner ^ OWNER_W'($urandom_range(15, 1));
			2: s.gen   = l.gen ^ (GEN_W'(1) << $urandom_range(GEN_W - 1));
			default: s.idx = l.idx + IDX_W'($urandom_range(15, 1));
		endcase
		return s;
	endfunction

	// ---------------------------------------------------------------- tests

	task automatic test_directed();
		lease_result_t r;
		logic [GEN_W-1:0] tag_a;
		int col;
		sender_idle_pct = 0;
		// never-written entry is free with tag 0, so an owner-0 lease matches it
		send_cmd(OP_CHECK, '0, '0, '0, '0, '0, 1'b1, r);
		send_cmd(OP_RELEASE, '0, '0, '0, '0, '0, 1'b1, r);
		// rejected acquires: owner 0, kind out of range, index out of range
		send_cmd(OP_ACQ, '0, '0, '0, '0, '0, 1'b0, r);
		send_cmd(OP_ACQ, '1, '0, '0, '1, '1, 1'b1, r);
		send_cmd(OP_ACQ, KIND_W'(KINDS - 1), '1, '1, '1, '0, 1'b0, r);
		// far corner, then a second claim on the taken entry
		send_cmd(OP_ACQ, KIND_W'(KINDS - 1), IDX_W'(INSTANCES - 1), '0, '1, '0, 1'b0, r);
		tag_a = r.ggen;
		send_cmd(OP_ACQ, KIND_W'(KINDS - 1), IDX_W'(INSTANCES - 1), '0, 4'd3, '0, 1'b0, r);
		// scans: count 0, full scan, count too short, owner 0
		send_cmd(OP_ACQ_ANY, KIND_W'(KINDS - 1), '0, '0, 4'd1, '0, 1'b0, r);
		send_cmd(OP_ACQ_ANY, KIND_W'(KINDS - 1), '0, '1, 4'd1, '0, 1'b0, r);
		send_cmd(OP_ACQ_ANY, KIND_W'(KINDS - 1), '0, 4'd1, 4'd1, '0, 1'b0, r);
		send_cmd(OP_ACQ_ANY, '1, '0, 4'd8, '0, '1, 1'b1, r);
		// checks of the corner lease: not held, good, bad tag
		send_cmd(OP_CHECK, KIND_W'(KINDS - 1), IDX_W'(INSTANCES - 1), '0, '1, tag_a, 1'b0, r);
		send_cmd(OP_CHECK, KIND_W'(KINDS - 1), IDX_W'(INSTANCES - 1), '0, '1, tag_a, 1'b1, r);
		send_cmd(OP_CHECK, KIND_W'(KINDS - 1), IDX_W'(INSTANCES - 1), '0, '1, '1, 1'b1, r);
		// release with a bad tag, then a good one; the tag stays on the entry
		send_cmd(OP_RELEASE, KIND_W'(KINDS - 1), IDX_W'(INSTANCES - 1), '0, '1,
			tag_a ^ 32'h8000_0000, 1'b1, r);
		send_cmd(OP_RELEASE, KIND_W'(KINDS - 1), IDX_W'(INSTANCES - 1), '0, '1, tag_a, 1'b1, r);
		send_cmd(OP_CHECK, KIND_W'(KINDS - 1), IDX_W'(INSTANCES - 1), '0, '1, tag_a, 1'b1, r);
		send_cmd(OP_CHECK, KIND_W'(KINDS - 1), IDX_W'(INSTANCES - 1), '0, '0, tag_a, 1'b1, r);
		send_cmd(OP_ACQ, KIND_W'(KINDS - 1), IDX_W'(INSTANCES - 1), '0, 4'd5, '0, 1'b0, r);
		// fill row 1 by scans, then one scan too many
		for (col = 0; col < INSTANCES; col++)
			send_cmd(OP_ACQ_ANY, KIND_W'(1), '0, '1, OWNER_W'(col + 1), '0, 1'b0, r);
		send_cmd(OP_ACQ_ANY, KIND_W'(1), '0, 4'd8, 4'd2, '0, 1'b0, r);
		drain_results();
	endtask

	// Mostly well-formed lease lifecycles with random content, plus noise
	task automatic test_random_traffic(input int n_items, input int idle_pct);
		lease_result_t r;
		lease_t l;
		logic [KIND_W-1:0] k;
		logic [OWNER_W-1:0] ow;
		int n;
		int pick;
		int sel;
		sender_idle_pct = idle_pct;
		for (n = 0; n < n_items; n++) begin
			pick = $urandom_range(99);
			if (held_leases.size() == 0 && pick < 85)
				pick = 0;
			else if (held_leases.size() > 24 && pick < 30)
				pick = pick + 50;
			if (pick < 30) begin
				// acquire on a valid row by a real owner
				k  = KIND_W'($urandom_range(KINDS - 1));
				ow = OWNER_W'($urandom_range(15, 1));
				if ($urandom_range(1)) begin
					send_cmd(OP_ACQ, k, IDX_W'($urandom_range(INSTANCES - 1)), IDX_W'($urandom),
						ow, GEN_W'($urandom), 1'($urandom), r);
				end else begin
					send_cmd(OP_ACQ_ANY, k, IDX_W'($urandom), IDX_W'($urandom_range(15)),
						ow, GEN_W'($urandom), 1'($urandom), r);
				end
				if (r.ok) begin
					l.kind  = k;
					l.idx   = IDX_W'(r.gidx);
					l.owner = ow;
					l.gen   = r.ggen;
					l.held  = 1'b1;
					held_leases.push_back(l);
				end
			end else if (pick < 85) begin
				// check or release a lease we hold, sometimes spoiled
				sel = $urandom_range(held_leases.size() - 1);
				l = held_leases[sel];
				if ($urandom_range(3) == 0)
					l = spoil_lease(l);
				send_cmd((pick < 55) ? OP_CHECK : OP_RELEASE, l.kind, l.idx, IDX_W'($urandom),
					l.owner, l.gen, l.held, r);
				if (pick >= 55 && r.ok)
					held_leases.delete(sel);
			end else begin
				// noise: every field random
				send_cmd(op_t'($urandom_range(3)), KIND_W'($urandom), IDX_W'($urandom),
					IDX_W'($urandom), OWNER_W'($urandom), GEN_W'($urandom), 1'($urandom), r);
			end
		end
		drain_results();
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin : main_seq
		int s;
		arst_n           <= 1'b0;
		start            <= 1'b0;
		op               <= OP_ACQ;
		kind             <= '0;
		index            <= '0;
		count            <= '0;
		owner            <= '0;
		lease_generation <= '0;
		lease_held       <= 1'b0;
		mismatches      = 0;
		sender_idle_pct = 0;
		for (s = 0; s < SLOTS; s++) begin
			slot_owner[s] = '0;
			slot_tag[s]   = '0;
		end
		next_tag = GEN_W'(1);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_traffic(450, 0);
		test_random_traffic(450, 79);
		test_random_traffic(450, 37);
		test_random_traffic(400, 0);

		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
